### rtl/core/ttlp_pkg.sv
package ttlp_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS      = 32;
    localparam int HOLD_BITS      = 16;
    localparam int RADIUS_BITS    = 8;
    localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_JITTER     = 2'd1;

    localparam logic [HOLD_BITS-1:0]      LONG_PRESS_RST = 16'd500;
    localparam logic [RADIUS_BITS-1:0]    JITTER_RST     = 8'd10;
    localparam logic [RADIUS_SQ_BITS-1:0] JITTER_SQ_RST  = 16'd100;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_TAP       = 2'd1,
        EV_SECONDARY = 2'd2
    } ttlp_event_t;

    typedef struct packed {
        logic is_down;
        logic hold_fired;
    } ttlp_flags_t;

    typedef struct packed {
        ttlp_flags_t flags;
        logic        restart;
        ttlp_event_t ev;
        logic        ev_at_start;
    } ttlp_upd_t;

endpackage

### rtl/core/ttlp_eval.sv
module ttlp_eval #(
    parameter int COORD_BITS = ttlp_pkg::COORD_BITS_DEF
) (
    input  ttlp_pkg::ttlp_flags_t                 flags,
    input  logic [ttlp_pkg::TIME_BITS-1:0]        start_time,
    input  logic [COORD_BITS-1:0]                 start_x,
    input  logic [COORD_BITS-1:0]                 start_y,
    input  logic                                  touched,
    input  logic                                  alt_button,
    input  logic [COORD_BITS-1:0]                 pos_x,
    input  logic [COORD_BITS-1:0]                 pos_y,
    input  logic [ttlp_pkg::TIME_BITS-1:0]        now_ms,
    input  logic [ttlp_pkg::HOLD_BITS-1:0]        long_press_ms,
    input  logic [ttlp_pkg::RADIUS_SQ_BITS-1:0]   radius_sq,
    output ttlp_pkg::ttlp_upd_t                   upd
);
    import ttlp_pkg::*;

    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int DIST_BITS = SQ_BITS + 1;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_BITS-1:0]    dx_sq;
    logic [SQ_BITS-1:0]    dy_sq;
    logic [DIST_BITS-1:0]  dist_sq;
    logic                  drifted;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  held_long;

    assign dx      = (pos_x >= start_x) ? (pos_x - start_x) : (start_x - pos_x);
    assign dy      = (pos_y >= start_y) ? (pos_y - start_y) : (start_y - pos_y);
    assign dx_sq   = SQ_BITS'(dx) * SQ_BITS'(dx);
    assign dy_sq   = SQ_BITS'(dy) * SQ_BITS'(dy);
    assign dist_sq = DIST_BITS'(dx_sq) + DIST_BITS'(dy_sq);
    assign drifted = dist_sq > DIST_BITS'(radius_sq);

    assign elapsed   = now_ms - start_time;
    assign held_long = elapsed >= TIME_BITS'(long_press_ms);

    always_comb
    begin
        upd             = '0;
        upd.flags       = flags;
        upd.ev          = EV_NONE;
        if (touched)
        begin
            if (alt_button)
            begin
                upd.flags = '0;
                upd.ev    = EV_SECONDARY;
            end
            else if (!flags.is_down)
            begin
                upd.flags.is_down    = 1'b1;
                upd.flags.hold_fired = 1'b0;
                upd.restart          = 1'b1;
            end
            else if (drifted)
            begin
                upd.flags.hold_fired = 1'b0;
                upd.restart          = 1'b1;
            end
            else if (!flags.hold_fired && held_long)
            begin
                upd.flags.hold_fired = 1'b1;
                upd.ev               = EV_SECONDARY;
                upd.ev_at_start      = 1'b1;
            end
        end
        else if (flags.is_down)
        begin
            if (!flags.hold_fired)
            begin
                upd.ev          = EV_TAP;
                upd.ev_at_start = 1'b1;
            end
            upd.flags = '0;
        end
    end

endmodule

### rtl/core/touch_tap_longpress_classifier_core.sv
// Tap and long-press classifier. Each sample transfer yields exactly one event
// transfer (event_res none, tap or secondary tap, with its point). One sample
// is taken every cycle while sample_stall is low; a sample reaches the event
// port through the sample register and then the event register, around the
// single pass of distance and hold-time compares. A stalled event port holds
// the event register and, once the sample register is also full, stalls the
// sample port. cfg_ready is always high; write the registers only while idle.
module touch_tap_longpress_classifier_core #(
    parameter int COORD_BITS = ttlp_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ttlp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ttlp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic                                 touched,
    input  logic                                 alt_button,
    input  logic [COORD_BITS-1:0]                pos_x,
    input  logic [COORD_BITS-1:0]                pos_y,
    input  logic [ttlp_pkg::TIME_BITS-1:0]       now_ms,
    output logic                                 event_valid,
    input  logic                                 event_stall,
    output logic [1:0]                           event_res,
    output logic [COORD_BITS-1:0]                event_x,
    output logic [COORD_BITS-1:0]                event_y
);
    import ttlp_pkg::*;

    logic                       cfg_write;
    logic [HOLD_BITS-1:0]       long_press_reg;
    logic [RADIUS_SQ_BITS-1:0]  radius_sq_reg;
    logic [RADIUS_BITS-1:0]     radius_next;

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic                       touched_reg;
    logic                       alt_reg;
    logic [COORD_BITS-1:0]      x_reg;
    logic [COORD_BITS-1:0]      y_reg;
    logic [TIME_BITS-1:0]       now_reg;

    ttlp_flags_t                flags_reg;
    logic [TIME_BITS-1:0]       start_time_reg;
    logic [COORD_BITS-1:0]      start_x_reg;
    logic [COORD_BITS-1:0]      start_y_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    ttlp_event_t                ev_reg;
    logic [COORD_BITS-1:0]      ev_x_reg;
    logic [COORD_BITS-1:0]      ev_y_reg;

    logic                       take;
    logic                       advance;
    ttlp_upd_t                  upd;
    logic [COORD_BITS-1:0]      ev_x_next;
    logic [COORD_BITS-1:0]      ev_y_next;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign radius_next = cfg_data[RADIUS_BITS-1:0];

    assign advance        = in_valid_reg && (!out_valid_reg || !event_stall);
    assign sample_stall   = in_valid_reg && out_valid_reg && event_stall;
    assign take           = sample_valid && !sample_stall;
    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && event_stall);

    ttlp_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .flags         (flags_reg),
        .start_time    (start_time_reg),
        .start_x       (start_x_reg),
        .start_y       (start_y_reg),
        .touched       (touched_reg),
        .alt_button    (alt_reg),
        .pos_x         (x_reg),
        .pos_y         (y_reg),
        .now_ms        (now_reg),
        .long_press_ms (long_press_reg),
        .radius_sq     (radius_sq_reg),
        .upd           (upd)
    );

    always_comb
    begin
        ev_x_next = '0;
        ev_y_next = '0;
        if (upd.ev != EV_NONE)
        begin
            ev_x_next = upd.ev_at_start ? start_x_reg : x_reg;
            ev_y_next = upd.ev_at_start ? start_y_reg : y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RST;
            radius_sq_reg  <= JITTER_SQ_RST;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            flags_reg      <= '0;
            start_time_reg <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_LONG_PRESS)
            begin
                long_press_reg <= cfg_data[HOLD_BITS-1:0];
            end
            if (cfg_write && cfg_index == CFG_JITTER)
            begin
                radius_sq_reg <= RADIUS_SQ_BITS'(radius_next) * RADIUS_SQ_BITS'(radius_next);
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                flags_reg <= upd.flags;
                if (upd.restart)
                begin
                    start_time_reg <= now_reg;
                    start_x_reg    <= x_reg;
                    start_y_reg    <= y_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            touched_reg <= touched;
            alt_reg     <= alt_button;
            x_reg       <= pos_x;
            y_reg       <= pos_y;
            now_reg     <= now_ms;
        end
        if (advance)
        begin
            ev_reg   <= upd.ev;
            ev_x_reg <= ev_x_next;
            ev_y_reg <= ev_y_next;
        end
    end

    assign event_valid = out_valid_reg;
    assign event_res   = ev_reg;
    assign event_x     = ev_x_reg;
    assign event_y     = ev_y_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> in_valid_reg)
        else $error("sample stall without a held sample");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> in_valid_reg)
        else $error("transferred sample not held");

    a_fired_needs_down: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.hold_fired |-> flags_reg.is_down)
        else $error("hold fired while released");

    a_none_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && ev_reg == EV_NONE) |-> (event_x == '0 && event_y == '0))
        else $error("empty event carries a point");

endmodule
